// File: sv/mstu_pkg.sv
// Package for the millisecond timestamp unwrapper.
// Holds the channel payload types, the front-to-back queue entry and the fixed constants.
// No dependencies.
package mstu_pkg;

    localparam int unsigned RAW_W   = 32;
    localparam int unsigned TIME_W  = 64;
    localparam int unsigned DMS_W   = RAW_W + 1;   // unwrapped step in ms, up to 2^32
    localparam int unsigned DUS_W   = DMS_W + 10;  // step in us after the x1000

    localparam logic [RAW_W-1:0]  PPS_PERIOD_MS  = 32'd1000;
    localparam logic [RAW_W-1:0]  PPS_WRAP_MS    = 32'd500;
    localparam logic [RAW_W-1:0]  PPS_HIGH_MS    = 32'd900;
    localparam logic [RAW_W-1:0]  PPS_LOW_MS     = 32'd100;
    localparam logic [RAW_W-1:0]  COUNTER_MIN_MS = 32'd1500;
    localparam logic [RAW_W-1:0]  WRAP_ZONE_MS   = 32'hFFFF_F000;
    localparam logic [RAW_W-1:0]  HALF_RANGE_MS  = 32'h7FFF_FFFF;
    localparam logic [9:0]        US_PER_MS      = 10'd1000;
    localparam logic [TIME_W-1:0] JUMP_US        = 64'd5_000_000;
    localparam logic [TIME_W-1:0] SLACK_US       = 64'd500_000;

    typedef enum logic [1:0] {
        EV_FIRST   = 2'd0,
        EV_ADVANCE = 2'd1,
        EV_REORDER = 2'd2,
        EV_RESTART = 2'd3
    } mstu_event_t;

    typedef struct packed {
        logic [RAW_W-1:0]  raw_ms;
        logic [TIME_W-1:0] host_time_us;
    } mstu_in_t;

    typedef struct packed {
        logic [TIME_W-1:0] timestamp_us;
        mstu_event_t       event_kind;
        logic              mode_reset;
    } mstu_out_t;

    // Classified sample handed from the front to the back
    typedef struct packed {
        logic [TIME_W-1:0] host_us;
        logic [DUS_W-1:0]  delta_us;
        mstu_event_t       kind;
        logic              mode;
    } mstu_entry_t;

endpackage

// File: sv/mstu_front.sv
// Front end of the timestamp unwrapper: classifies each accepted sample.
// Tracks raw/host history and mode flags; depends on mstu_pkg.
module mstu_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr,
    input  logic                in_fire,
    input  mstu_pkg::mstu_in_t  in_data,
    output mstu_pkg::mstu_entry_t entry
);
    import mstu_pkg::*;

    logic              inner_started_reg;
    logic              outer_started_reg;
    logic [RAW_W-1:0]  raw_prev_reg;
    logic [TIME_W-1:0] last_host_reg;

    logic [RAW_W-1:0]  raw;
    logic [TIME_W-1:0] host;
    logic [RAW_W-1:0]  back_ms;
    logic              is_back;
    logic              hold_window;
    logic              to_counter;
    logic              wrap32;
    logic              to_pps;
    logic              mode_sw;
    logic              first;
    logic              pps_wrap;
    logic              jump;
    logic [TIME_W-1:0] elapsed;
    logic [DMS_W-1:0]  delta_ms;
    logic [DUS_W-1:0]  delta_us;
    mstu_event_t       kind;

    assign raw     = in_data.raw_ms;
    assign host    = in_data.host_time_us;
    assign back_ms = raw_prev_reg - raw;
    assign is_back = raw < raw_prev_reg;

    // small step back never counts as a mode switch
    assign hold_window = is_back && (back_ms <= PPS_WRAP_MS);
    assign to_counter  = (raw_prev_reg <= PPS_PERIOD_MS) && (raw > COUNTER_MIN_MS);
    assign wrap32      = (raw_prev_reg >= WRAP_ZONE_MS) && (raw <= PPS_PERIOD_MS);
    assign to_pps      = (raw_prev_reg > PPS_PERIOD_MS) && !wrap32 && (raw <= PPS_PERIOD_MS);
    assign mode_sw     = outer_started_reg && !hold_window && (to_counter || to_pps);
    assign first       = mode_sw || !inner_started_reg;

    assign pps_wrap = (raw_prev_reg >= PPS_HIGH_MS) && (raw_prev_reg <= PPS_PERIOD_MS) &&
                      (raw <= PPS_LOW_MS) && (back_ms > PPS_WRAP_MS);

    assign elapsed = (host >= last_host_reg) ? (host - last_host_reg) : '0;

    always_comb begin
        priority if (!is_back) begin
            delta_ms = {1'b0, raw - raw_prev_reg};
        end else if (back_ms > HALF_RANGE_MS) begin
            delta_ms = {1'b0, ~raw_prev_reg} + {1'b0, raw} + DMS_W'(1);
        end else begin
            delta_ms = {1'b0, PPS_PERIOD_MS - raw_prev_reg + raw};
        end
    end

    // one small constant multiply per sample
    assign delta_us = DUS_W'(delta_ms) * DUS_W'(US_PER_MS);

    assign jump = (TIME_W'(delta_us) > JUMP_US) &&
                  ((elapsed + SLACK_US) < TIME_W'(delta_us >> 2));

    always_comb begin
        priority if (first) begin
            kind = EV_FIRST;
        end else if (!is_back) begin
            kind = jump ? EV_RESTART : EV_ADVANCE;
        end else if (back_ms > HALF_RANGE_MS) begin
            kind = EV_ADVANCE;
        end else if (pps_wrap) begin
            kind = EV_ADVANCE;
        end else if (back_ms <= PPS_WRAP_MS) begin
            kind = EV_REORDER;
        end else begin
            kind = EV_RESTART;
        end
    end

    assign entry.host_us  = host;
    assign entry.delta_us = delta_us;
    assign entry.kind     = kind;
    assign entry.mode     = mode_sw;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) begin
            inner_started_reg <= 1'b0;
            outer_started_reg <= 1'b0;
            raw_prev_reg      <= '0;
            last_host_reg     <= '0;
        end else if (in_fire) begin
            outer_started_reg <= 1'b1;
            if (kind != EV_REORDER) begin
                inner_started_reg <= 1'b1;
                raw_prev_reg      <= raw;
                last_host_reg     <= host;
            end
        end
    end

endmodule

// File: sv/mstu_queue.sv
// Short FIFO between the classifying front and the timestamp back end.
// Depends on mstu_pkg for the entry type.
module mstu_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  mstu_pkg::mstu_entry_t wr_data,
    input  logic                  pop,
    output mstu_pkg::mstu_entry_t rd_data,
    output logic                  not_empty,
    output logic                  full
);
    import mstu_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    mstu_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign not_empty = count_reg != '0;
    assign full      = count_reg == CNT_W'(DEPTH);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// File: sv/mstu_back.sv
// Back end of the timestamp unwrapper: anchor, accumulation and output floor.
// Holds the host anchor register and the result register; depends on mstu_pkg.
module mstu_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr,
    input  logic [63:0]           cfg_data,
    input  logic                  q_valid,
    input  mstu_pkg::mstu_entry_t q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mstu_pkg::mstu_out_t   out_data
);
    import mstu_pkg::*;

    logic [TIME_W-1:0] host_anchor_reg;
    logic [TIME_W-1:0] base_reg;       // anchor + accumulated us
    logic [TIME_W-1:0] inner_last_reg;
    logic [TIME_W-1:0] outer_last_reg;
    logic              out_valid_reg;
    mstu_out_t         out_reg;

    logic [TIME_W-1:0] cand;
    logic [TIME_W-1:0] inner_inc;
    logic [TIME_W-1:0] restart_anchor;
    logic [TIME_W-1:0] first_anchor;
    logic [TIME_W-1:0] base_next;
    logic [TIME_W-1:0] inner_next;
    logic [TIME_W-1:0] ts_next;
    logic [TIME_W-1:0] host;

    assign host      = q_data.host_us;
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cand           = base_reg + TIME_W'(q_data.delta_us);
    assign inner_inc      = inner_last_reg + TIME_W'(1);
    assign restart_anchor = (host > inner_last_reg) ? host : inner_inc;
    // zero anchor register means take the first host observation
    assign first_anchor   = (q_data.mode || host_anchor_reg == '0) ? host : host_anchor_reg;

    always_comb begin
        unique case (q_data.kind)
            EV_FIRST: begin
                base_next  = first_anchor;
                inner_next = first_anchor;
            end
            EV_ADVANCE: begin
                base_next  = cand;
                inner_next = (cand > inner_last_reg) ? cand : inner_inc;
            end
            EV_REORDER: begin
                base_next  = base_reg;
                inner_next = inner_inc;
            end
            EV_RESTART: begin
                base_next  = restart_anchor;
                inner_next = restart_anchor;
            end
            default: begin
                base_next  = base_reg;
                inner_next = inner_last_reg;
            end
        endcase
    end

    assign ts_next = (outer_last_reg != '0 && inner_next <= outer_last_reg) ?
                     outer_last_reg + TIME_W'(1) : inner_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_anchor_reg <= '0;
            base_reg        <= '0;
            inner_last_reg  <= '0;
            outer_last_reg  <= '0;
        end else if (cfg_wr) begin
            host_anchor_reg <= cfg_data;
            base_reg        <= '0;
            inner_last_reg  <= '0;
            outer_last_reg  <= '0;
        end else if (q_pop) begin
            base_reg       <= base_next;
            inner_last_reg <= inner_next;
            outer_last_reg <= ts_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (q_pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg.timestamp_us <= ts_next;
            out_reg.event_kind   <= q_data.kind;
            out_reg.mode_reset   <= q_data.mode;
        end
    end

endmodule

// File: sv/ms_timestamp_unwrapper.sv
// Top level of the millisecond timestamp unwrapper.
// Instantiates mstu_front, mstu_queue and mstu_back; depends on mstu_pkg.
//
//  Channel | Ports                          | Transaction
//  --------+--------------------------------+--------------------------------------
//  s_      | s_valid  s_ready  s_data       | raw_ms + host_time_us sample in
//  m_      | m_valid  m_ready  m_data       | timestamp_us, event_kind, mode_reset
//  cfg_    | cfg_valid cfg_ready cfg_data   | host_anchor_us write, clears state
//
// One transaction per cycle sustained while m_ready stays high; an accepted sample is
// classified and written to a queue slot, then the back end loads the result register.
// The front recurrence (raw/host history, one 33x10 multiply) and the back recurrence
// (three 64-bit adds, three magnitude compares) each close combinationally, unpipelined.
// Reset (aresetn low, synchronous) clears all history; a cfg_ write loads the host anchor and
// clears front/back history, not the queue or a pending result. No clearing sweep: the block
// is ready right after. s_ready drops only when the QUEUE_DEPTH-entry queue is full, which
// needs m_ to stall; a finished result waiting on m_ready does not block new input.
module ms_timestamp_unwrapper #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  mstu_pkg::mstu_in_t   s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output mstu_pkg::mstu_out_t  m_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [63:0]          cfg_data
);
    import mstu_pkg::*;

    logic        in_fire;
    logic        cfg_wr;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;
    mstu_entry_t front_entry;
    mstu_entry_t q_head;

    // register port always takes a write; the host side is to write only when idle (not enforced here)
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;

    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    mstu_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .in_fire (in_fire),
        .in_data (s_data),
        .entry   (front_entry)
    );

    mstu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .wr_data   (front_entry),
        .pop       (q_pop),
        .rd_data   (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    mstu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .cfg_data  (cfg_data),
        .q_valid   (q_not_empty),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// File: sv/mstu_checker.sv
// Port-level assertions for the timestamp unwrapper, bound to the top level.
// Depends on mstu_pkg and ms_timestamp_unwrapper.
module mstu_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mstu_pkg::mstu_out_t m_data,
    input logic                cfg_valid,
    input logic                cfg_ready
);
    import mstu_pkg::*;

    logic        out_fire;
    logic        last_ok_reg;
    logic [63:0] last_ts_reg;

    assign out_fire = m_valid && m_ready;

    // last delivered timestamp, usable for ordering unless zero or at the top
    always_ff @(posedge aclk) begin
        if (!aresetn || (cfg_valid && cfg_ready)) begin
            last_ok_reg <= 1'b0;
            last_ts_reg <= '0;
        end else if (out_fire) begin
            last_ok_reg <= (m_data.timestamp_us != '0) && (m_data.timestamp_us != '1);
            last_ts_reg <= m_data.timestamp_us;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_increasing: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire && last_ok_reg |-> m_data.timestamp_us > last_ts_reg)
        else $error("timestamp not strictly increasing");

    a_mode_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.mode_reset |-> m_data.event_kind == EV_FIRST)
        else $error("mode switch not reported as first sample");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

endmodule

bind ms_timestamp_unwrapper mstu_checker u_mstu_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
